[rtl/cdsg_pkg.sv]
// Shared types and constants for the clipped disc span generator.
// Used by cdsg_ctrl, cdsg_datapath and clipped_disc_span_generator; no dependencies.

package cdsg_pkg;

    localparam int COORD_BITS_DEF       = 12;
    localparam int RADIUS_INT_BITS_DEF  = 5;
    localparam int RADIUS_FRAC_BITS_DEF = 4;

    // Canvas size registers.
    localparam int                  CFG_BITS     = 13;
    localparam logic [CFG_BITS-1:0] CANVAS_RESET = 13'd1024;

    typedef enum logic {
        REG_CANVAS_WIDTH  = 1'b0,
        REG_CANVAS_HEIGHT = 1'b1
    } cdsg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ADJ,
        ST_FLUSH
    } cdsg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init;
        logic grow;
        logic shrink;
        logic row_take;
        logic flush;
    } cdsg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic grow_ok;
        logic shrink_ok;
        logic dj_at_end;
        logic span_ok;
        logic hold_valid;
        logic out_free;
    } cdsg_status_t;

endpackage

[rtl/cdsg_ctrl.sv]
// Sequencer for the clipped disc span generator: accepts a disc, walks its rows
// and steers the half-width search and span output. Depends on cdsg_pkg.

module cdsg_ctrl
    import cdsg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output cdsg_cmd_t    cmd,
    input  cdsg_status_t st
);

    cdsg_state_t state_reg;
    cdsg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                // One step of the half-width per cycle until it settles for this row.
                if (st.grow_ok)
                begin
                    cmd.grow = 1'b1;
                end
                else if (st.shrink_ok)
                begin
                    cmd.shrink = 1'b1;
                end
                else if (!(st.span_ok && st.hold_valid && !st.out_free))
                begin
                    cmd.row_take = 1'b1;
                    if (st.dj_at_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!(st.hold_valid && !st.out_free))
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Coverage is a prefix in the half-width, so a grow can never be followed by a shrink.
    a_no_shrink_after_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADJ && st.grow_ok) |=> !st.shrink_ok)
        else $error("half-width shrank right after growing");

    // The held span is always drained before the next disc is taken.
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !st.hold_valid)
        else $error("held span left over in idle");

    // A span is only moved to the output register when that register can take it.
    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.row_take && st.span_ok && st.hold_valid) || (cmd.flush && st.hold_valid))
        |-> st.out_free)
        else $error("span pushed into a busy output register");
`endif

endmodule

[rtl/cdsg_datapath.sv]
// Datapath of the clipped disc span generator: disc registers, coverage checks,
// row and column clipping, one-span hold stage and output register. Depends on cdsg_pkg.

module cdsg_datapath
    import cdsg_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int RADIUS_INT_BITS  = RADIUS_INT_BITS_DEF,
    parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  cdsg_cmd_t                                 cmd,
    output cdsg_status_t                              st,
    input  logic [COORD_BITS-1:0]                     center_x,
    input  logic [COORD_BITS-1:0]                     center_y,
    input  logic [RADIUS_INT_BITS+RADIUS_FRAC_BITS-1:0] radius_q4,
    input  logic [CFG_BITS-1:0]                       canvas_width,
    input  logic [CFG_BITS-1:0]                       canvas_height,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [COORD_BITS-1:0]                     span_row,
    output logic [COORD_BITS-1:0]                     span_x_start,
    output logic [COORD_BITS-1:0]                     span_x_end,
    output logic                                      span_last
);

    localparam int C   = COORD_BITS;
    localparam int RIB = RADIUS_INT_BITS;
    localparam int F   = RADIUS_FRAC_BITS;
    localparam int RB  = RIB + F;
    localparam int TW  = RB + 2;                    // 2*radius + 2^F
    localparam int BW  = 2 * TW;                    // squared bound
    localparam int DW  = 2 * RIB + 3;               // di^2 + dj^2
    localparam int CW  = BW + 1;                    // compare width
    localparam int EW  = ((C > RIB) ? C : RIB) + 2; // signed row and column math
    localparam int LW  = ((C + 1) > CFG_BITS) ? (C + 1) : CFG_BITS;

    // Disc and walk registers.
    logic [C-1:0]        cx_reg;
    logic [C-1:0]        cy_reg;
    logic [RB-1:0]       rq_reg;
    logic [BW-1:0]       bound_reg;
    logic [RIB:0]        w_reg;
    logic signed [RIB:0] dj_reg;

    // Hold stage and output register.
    logic         hold_valid_reg;
    logic         hold_valid_next;
    logic [C-1:0] hold_row_reg;
    logic [C-1:0] hold_xs_reg;
    logic [C-1:0] hold_xe_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [C-1:0] out_row_reg;
    logic [C-1:0] out_xs_reg;
    logic [C-1:0] out_xe_reg;
    logic         out_last_reg;

    logic         push;
    logic         push_last;
    logic         take_span;

    logic [RIB:0]        r_ext;
    logic [TW-1:0]       twice;
    logic [BW-1:0]       bound_next;
    logic [RIB:0]        dj_abs;
    logic [RIB:0]        w_inc;
    logic [DW-1:0]       dj_sq;
    logic [DW-1:0]       d2_cur;
    logic [DW-1:0]       d2_inc;
    logic                cov_cur;
    logic                cov_inc;

    logic [LW-1:0]       lim_ext;
    logic [LW-1:0]       cw_ext;
    logic [LW-1:0]       ch_ext;
    logic [C:0]          wlim;
    logic [C:0]          hlim;
    logic signed [EW-1:0] wl_s;
    logic signed [EW-1:0] hl_s;
    logic signed [EW-1:0] row_s;
    logic signed [EW-1:0] xs_s;
    logic signed [EW-1:0] xe_s;
    logic signed [EW-1:0] xs_c;
    logic signed [EW-1:0] xe_c;
    logic                 row_ok;
    logic                 span_ok;

    // Radius bound (2*radius + 2^F)^2, registered in the init cycle.
    assign r_ext      = {1'b0, rq_reg[RB-1 -: RIB]};
    assign twice      = {1'b0, rq_reg, 1'b0} + (TW'(1) << F);
    assign bound_next = BW'(twice) * BW'(twice);

    // Coverage at the current half-width and at one more.
    assign dj_abs  = dj_reg[RIB] ? $unsigned(-dj_reg) : $unsigned(dj_reg);
    assign w_inc   = w_reg + 1'b1;
    assign dj_sq   = DW'(dj_abs) * DW'(dj_abs);
    assign d2_cur  = DW'(w_reg) * DW'(w_reg) + dj_sq;
    assign d2_inc  = DW'(w_inc) * DW'(w_inc) + dj_sq;
    assign cov_cur = (CW'(d2_cur) << (2 * F + 2)) <= CW'(bound_reg);
    assign cov_inc = (CW'(d2_inc) << (2 * F + 2)) <= CW'(bound_reg);

    // Canvas sizes beyond the coordinate range saturate at 2^COORD_BITS.
    assign lim_ext = LW'(1) << C;
    assign cw_ext  = LW'(canvas_width);
    assign ch_ext  = LW'(canvas_height);
    assign wlim    = (cw_ext > lim_ext) ? lim_ext[C:0] : cw_ext[C:0];
    assign hlim    = (ch_ext > lim_ext) ? lim_ext[C:0] : ch_ext[C:0];
    assign wl_s    = $signed(EW'(wlim));
    assign hl_s    = $signed(EW'(hlim));

    assign row_s   = $signed(EW'(cy_reg)) + EW'(dj_reg);
    assign xs_s    = $signed(EW'(cx_reg)) - $signed(EW'(w_reg));
    assign xe_s    = $signed(EW'(cx_reg)) + $signed(EW'(w_reg));
    assign xs_c    = xs_s[EW-1] ? '0 : xs_s;
    assign xe_c    = (xe_s >= wl_s) ? (wl_s - EW'(1)) : xe_s;
    assign row_ok  = !row_s[EW-1] && (row_s < hl_s);
    assign span_ok = row_ok && (xs_c <= xe_c);

    assign st.grow_ok    = (w_reg < r_ext) && cov_inc;
    assign st.shrink_ok  = (w_reg != '0) && !cov_cur;
    assign st.dj_at_end  = (dj_reg == $signed(r_ext));
    assign st.span_ok    = span_ok;
    assign st.hold_valid = hold_valid_reg;
    assign st.out_free   = !out_valid_reg || out_ready;

    // A found span waits in the hold stage until the next one shows whether it is the last.
    always_comb
    begin
        take_span       = cmd.row_take && span_ok;
        push            = 1'b0;
        push_last       = 1'b0;
        hold_valid_next = hold_valid_reg;
        if (take_span)
        begin
            push            = hold_valid_reg;
            hold_valid_next = 1'b1;
        end
        if (cmd.flush)
        begin
            push            = hold_valid_reg;
            push_last       = 1'b1;
            hold_valid_next = 1'b0;
        end
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            rq_reg <= radius_q4;
        end
        if (cmd.init)
        begin
            bound_reg <= bound_next;
            w_reg     <= '0;
            dj_reg    <= -$signed(r_ext);
        end
        else if (cmd.grow)
        begin
            w_reg <= w_inc;
        end
        else if (cmd.shrink)
        begin
            w_reg <= w_reg - 1'b1;
        end
        else if (cmd.row_take)
        begin
            dj_reg <= dj_reg + $signed((RIB+1)'(1));
        end
        if (take_span)
        begin
            hold_row_reg <= row_s[C-1:0];
            hold_xs_reg  <= xs_c[C-1:0];
            hold_xe_reg  <= xe_c[C-1:0];
        end
        if (push)
        begin
            out_row_reg  <= hold_row_reg;
            out_xs_reg   <= hold_xs_reg;
            out_xe_reg   <= hold_xe_reg;
            out_last_reg <= push_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign span_row     = out_row_reg;
    assign span_x_start = out_xs_reg;
    assign span_x_end   = out_xe_reg;
    assign span_last    = out_last_reg;

endmodule

[rtl/clipped_disc_span_generator.sv]
// Top level of the clipped disc span generator: stream ports, canvas size
// registers on the APB port, controller and datapath. Depends on cdsg_pkg.
//
// Usage:
//   Each input item on the s_axis channel is one disc: center column, center row
//   and radius with RADIUS_FRAC_BITS fraction bits. For every canvas row the disc
//   covers, one span item (row, first column, last column) leaves on m_axis, rows
//   ascending; tlast marks the final span of a disc. A disc that covers nothing on
//   the canvas produces no item at all.
//   canvas_width and canvas_height sit at byte addresses 0 and 4 of the APB port.
//   The user must write them only while the block is idle; the block does not enforce this.
// Operation:
//   One disc at a time. The rows are walked in order, and within each row the half-width
//   moves one step per unit of change, using a single pair of coverage comparators.
//   A span reaches the output only once the next span is found, or at the end of the
//   disc, since each span is held until it is known whether it is the last.
// Reset and stalls:
//   Reset returns the sequencer to idle, empties the output and sets both canvas
//   sizes to 1024. A stalled receiver holds the current span item; the search
//   pauses only when a new span must move into the output register. A new disc
//   is accepted as soon as the final span is in the output register.

module clipped_disc_span_generator
    import cdsg_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int RADIUS_INT_BITS  = RADIUS_INT_BITS_DEF,
    parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_BITS_DEF,
    localparam int RB     = RADIUS_INT_BITS + RADIUS_FRAC_BITS,
    localparam int IN_TW  = ((2 * COORD_BITS + RB + 7) / 8) * 8,
    localparam int OUT_TW = ((3 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Disc items in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,  // center_x, center_y, radius_q4, zero fill
    // Span items out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata,  // span_row, span_x_start, span_x_end, zero fill
    output logic              m_axis_tlast
);

    localparam int C = COORD_BITS;

    logic [CFG_BITS-1:0] canvas_width_reg;
    logic [CFG_BITS-1:0] canvas_width_next;
    logic [CFG_BITS-1:0] canvas_height_reg;
    logic [CFG_BITS-1:0] canvas_height_next;
    logic                cfg_write;
    cdsg_reg_t           cfg_sel;

    cdsg_cmd_t    cmd;
    cdsg_status_t st;

    logic [C-1:0] span_row;
    logic [C-1:0] span_x_start;
    logic [C-1:0] span_x_end;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cdsg_reg_t'(paddr[2]);

    always_comb
    begin
        canvas_width_next  = canvas_width_reg;
        canvas_height_next = canvas_height_reg;
        prdata             = '0;
        unique case (cfg_sel)
            REG_CANVAS_WIDTH:
            begin
                prdata = 32'(canvas_width_reg);
                if (cfg_write)
                begin
                    canvas_width_next = pwdata[CFG_BITS-1:0];
                end
            end
            REG_CANVAS_HEIGHT:
            begin
                prdata = 32'(canvas_height_reg);
                if (cfg_write)
                begin
                    canvas_height_next = pwdata[CFG_BITS-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_RESET;
            canvas_height_reg <= CANVAS_RESET;
        end
        else
        begin
            canvas_width_reg  <= canvas_width_next;
            canvas_height_reg <= canvas_height_next;
        end
    end

    cdsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .st       (st)
    );

    cdsg_datapath #(
        .COORD_BITS       (COORD_BITS),
        .RADIUS_INT_BITS  (RADIUS_INT_BITS),
        .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .center_x      (s_axis_tdata[C-1:0]),
        .center_y      (s_axis_tdata[2*C-1:C]),
        .radius_q4     (s_axis_tdata[2*C+RB-1:2*C]),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .span_row      (span_row),
        .span_x_start  (span_x_start),
        .span_x_end    (span_x_end),
        .span_last     (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TW'({span_x_end, span_x_start, span_row});

endmodule

[verif/clipped_disc_span_generator_tb.sv]
// Self-checking testbench for clipped_disc_span_generator: sends disc items,
// predicts the clipped row spans of each disc and checks every span item.
// Depends on cdsg_pkg and the clipped_disc_span_generator RTL.
`timescale 1ns / 1ps

module clipped_disc_span_generator_tb;
    import cdsg_pkg::*;

    localparam int COORD_MAX    = (1 << COORD_BITS_DEF) - 1;
    localparam int CANVAS_MAX   = 1 << COORD_BITS_DEF;
    localparam int QUIET_CYCLES = 200;
    localparam int WATCHDOG_MAX = 2000;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] x_start;
        logic [11:0] x_end;
        logic        last;
    } span_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // center_x, center_y, radius_q4, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // span_row, span_x_start, span_x_end, zero fill
    logic        m_axis_tlast;

    span_t                pending_spans[$];
    logic [CFG_BITS-1:0]  canvas_w;
    logic [CFG_BITS-1:0]  canvas_h;
    int                   mismatches;
    int                   burst_left;
    int                   idle_cycles;

    clipped_disc_span_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    function automatic int clamp_canvas(input logic [CFG_BITS-1:0] size);
        return (int'(size) > CANVAS_MAX) ? CANVAS_MAX : int'(size);
    endfunction

    // Queues the spans of one disc under the current canvas size.
    task automatic predict_spans(input logic [11:0] cx, input logic [11:0] cy,
                                 input logic [8:0] rq);
        int    r;
        int    bound_sq;
        int    twice;
        int    wlim;
        int    hlim;
        int    dj;
        int    row;
        int    w;
        int    xs;
        int    xe;
        int    found;
        span_t s;

        r        = int'(rq) >> RADIUS_FRAC_BITS_DEF;
        twice    = 2 * int'(rq) + (1 << RADIUS_FRAC_BITS_DEF);
        bound_sq = twice * twice;
        wlim     = clamp_canvas(canvas_w);
        hlim     = clamp_canvas(canvas_h);
        found    = 0;
        for (dj = -r; dj <= r; dj++)
        begin
            row = int'(cy) + dj;
            if (row < 0 || row >= hlim)
                continue;
            // Shrink the half-width until the outermost pixel lies inside the disc.
            w = r;
            while (w > 0 && ((w * w + dj * dj) << (2 * RADIUS_FRAC_BITS_DEF + 2)) > bound_sq)
                w--;
            xs = int'(cx) - w;
            xe = int'(cx) + w;
            if (xs < 0)
                xs = 0;
            if (xe > wlim - 1)
                xe = wlim - 1;
            if (xs > xe)
                continue;
            s.row     = 12'(row);
            s.x_start = 12'(xs);
            s.x_end   = 12'(xe);
            s.last    = 1'b0;
            pending_spans.push_back(s);
            found++;
        end
        if (found > 0)
            pending_spans[pending_spans.size() - 1].last = 1'b1;
    endtask

    // Sends one disc item in bursts with random gaps between them.
    task automatic send_disc(input logic [11:0] cx, input logic [11:0] cy,
                             input logic [8:0] rq);
        int gap;

        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, rq, cy, cx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_spans(cx, cy, rq);
    endtask

    task automatic drain_spans();
        s_axis_tvalid <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge clk);
    endtask

    // A disc with no spans may still be in progress once the queue is empty.
    task automatic settle();
        drain_spans();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Writes one canvas register, then reads it back.
    task automatic write_canvas(input cdsg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_CANVAS_WIDTH)
            canvas_w = value[CFG_BITS-1:0];
        else
            canvas_h = value[CFG_BITS-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[CFG_BITS-1:0] !== value[CFG_BITS-1:0])
            note_mismatch($sformatf("register %s read expected %0d, got %0d",
                                    idx.name(), value[CFG_BITS-1:0],
                                    prdata[CFG_BITS-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [11:0] pick_coord(input int lim);
        int lo;
        int hi;

        case ($urandom_range(0, 3))
            0: return 12'($urandom_range(0, COORD_MAX));
            1: return 12'($urandom_range(0, lim - 1));
            2:
            begin
                lo = (lim > 40) ? lim - 40 : 0;
                hi = (lim + 40 < COORD_MAX) ? lim + 40 : COORD_MAX;
                return 12'($urandom_range(lo, hi));
            end
            default: return 12'($urandom_range(0, 40));
        endcase
    endfunction

    // Reset canvas: radius extremes, fraction steps and clipping on every side.
    task automatic test_default_canvas();
        send_disc(12'd0, 12'd0, 9'd0);
        send_disc(12'd512, 12'd512, 9'd511);
        send_disc(12'd0, 12'd0, 9'd511);
        send_disc(12'd1023, 12'd1023, 9'd511);
        send_disc(12'd4095, 12'd4095, 9'd511);
        send_disc(12'd1030, 12'd500, 9'd100);
        send_disc(12'd1026, 12'd500, 9'd48);
        send_disc(12'd300, 12'd200, 9'd15);
        send_disc(12'd300, 12'd200, 9'd16);
        send_disc(12'd300, 12'd200, 9'd8);
        send_disc(12'd300, 12'd1020, 9'd200);
        send_disc(12'd2047, 12'd0, 9'd24);
    endtask

    // Empty, single-pixel and over-range canvas sizes.
    task automatic test_canvas_extremes();
        settle();
        write_canvas(REG_CANVAS_WIDTH, 32'd0);
        send_disc(12'd10, 12'd10, 9'd100);
        settle();
        write_canvas(REG_CANVAS_WIDTH, 32'd1024);
        write_canvas(REG_CANVAS_HEIGHT, 32'd0);
        send_disc(12'd10, 12'd10, 9'd100);
        settle();
        write_canvas(REG_CANVAS_WIDTH, 32'd1);
        write_canvas(REG_CANVAS_HEIGHT, 32'd1);
        send_disc(12'd0, 12'd0, 9'd511);
        send_disc(12'd5, 12'd0, 9'd40);
        settle();
        // Upper bits are dropped; 8191 then clips to the coordinate range.
        write_canvas(REG_CANVAS_WIDTH, 32'hFFFF_FFFF);
        write_canvas(REG_CANVAS_HEIGHT, 32'd4096);
        send_disc(12'd4095, 12'd4095, 9'd511);
        send_disc(12'd4000, 12'd10, 9'd100);
        send_disc(12'd2048, 12'd2048, 9'd511);
    endtask

    task automatic test_random_discs();
        int          chunk;
        int          k;
        int          wlim;
        int          hlim;
        logic [31:0] w_val;
        logic [31:0] h_val;
        logic [8:0]  rq;

        for (chunk = 0; chunk < 4; chunk++)
        begin
            w_val = $urandom & ~32'h1FFF;
            h_val = $urandom & ~32'h1FFF;
            case (chunk)
                0:
                begin
                    w_val = $urandom_range(1, CANVAS_MAX);
                    h_val = $urandom_range(1, CANVAS_MAX);
                end
                1:
                begin
                    w_val = $urandom_range(1, 64);
                    h_val = $urandom_range(1, 64);
                end
                2:
                begin
                    w_val[12:0] = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
                    h_val[12:0] = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
                end
                default:
                begin
                    w_val[12:0] = 13'($urandom_range(1, 8191));
                    h_val[12:0] = 13'($urandom_range(1, 8191));
                end
            endcase
            settle();
            write_canvas(REG_CANVAS_WIDTH, w_val);
            write_canvas(REG_CANVAS_HEIGHT, h_val);
            wlim = clamp_canvas(canvas_w);
            hlim = clamp_canvas(canvas_h);
            for (k = 0; k < 50; k++)
            begin
                if (k == 20)
                    drain_spans();
                rq = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 47))
                                                 : 9'($urandom_range(0, 511));
                send_disc(pick_coord(wlim), pick_coord(hlim), rq);
            end
        end
    endtask

    task automatic check_span();
        span_t got;
        span_t want;

        got.row     = m_axis_tdata[11:0];
        got.x_start = m_axis_tdata[23:12];
        got.x_end   = m_axis_tdata[35:24];
        got.last    = m_axis_tlast;
        if (pending_spans.size() == 0)
        begin
            note_mismatch($sformatf("unexpected span row %0d x %0d..%0d last %0b",
                                    got.row, got.x_start, got.x_end, got.last));
        end
        else
        begin
            want = pending_spans.pop_front();
            if (got.row !== want.row || got.x_start !== want.x_start ||
                got.x_end !== want.x_end || got.last !== want.last)
                note_mismatch($sformatf(
                    "span expected row %0d x %0d..%0d last %0b, got row %0d x %0d..%0d last %0b",
                    want.row, want.x_start, want.x_end, want.last,
                    got.row, got.x_start, got.x_end, got.last));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_span();
    end

    // Receiver stalls: free-running, random, mostly ready or mostly stalled windows.
    initial
    begin : span_receiver
        int          mode;
        int          k;
        logic [15:0] pattern;

        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode    = $urandom_range(0, 3);
            pattern = 16'($urandom);
            for (k = 0; k < 16; k++)
            begin
                @(posedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= pattern[k];
                    2: m_axis_tready <= pattern[k] | pattern[(k + 1) % 16];
                    default: m_axis_tready <= pattern[k] & pattern[(k + 3) % 16];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 40'd0;
        canvas_w      = CANVAS_RESET;
        canvas_h      = CANVAS_RESET;
        mismatches    = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_canvas();
        test_canvas_extremes();
        test_random_discs();

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
